// ----- rtl/core/scd_pkg.sv -----
// package for the serial can frame deframer
// holds frame constants, field widths, kind and status codes; no dependencies
package scd_pkg;

    // frame layout
    localparam logic [7:0] START_BYTE  = 8'hAA;
    localparam logic [7:0] CMD_TYPE    = 8'h55;
    localparam int         CMD_LEN     = 20;
    localparam logic [3:0] DATA_NIBBLE = 4'hC;
    localparam int         DATA_EXTRA  = 5;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 5;
    localparam int PLEN_W  = 4;

    // kind of the current frame
    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_CMD     = 2'd1,
        KIND_DATA    = 2'd2,
        KIND_OTHER   = 2'd3
    } t_kind;

    // status reported with each word
    typedef enum logic [1:0] {
        ST_RECV     = 2'd0,
        ST_OK       = 2'd1,
        ST_CSUM_ERR = 2'd2,
        ST_DISCARD  = 2'd3
    } t_status;

endpackage

// ----- rtl/core/scd_in_if.sv -----
// input channel of the deframer: one received serial byte per word
// depends on scd_pkg for field widths
interface scd_in_if;
    logic                          valid;
    logic                          ready;
    logic [scd_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/scd_out_if.sv -----
// result channel of the deframer: the echoed byte with position, kind, payload length, status and end flag
// depends on scd_pkg for field widths and codes
interface scd_out_if;
    logic                          valid;
    logic                          ready;
    logic [scd_pkg::BYTE_W-1:0]    out_byte;
    logic [scd_pkg::INDEX_W-1:0]   byte_index;
    scd_pkg::t_kind                frame_kind;
    logic [scd_pkg::PLEN_W-1:0]    payload_length;
    scd_pkg::t_status              frame_status;
    logic                          frame_end;

    modport source (output valid, output out_byte, output byte_index, output frame_kind,
                    output payload_length, output frame_status, output frame_end,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_index, input frame_kind,
                    input payload_length, input frame_status, input frame_end,
                    output ready);
endinterface

// ----- rtl/core/serial_can_frame_deframer.sv -----
// serial can frame deframer: an accepted byte passes the input register, then the result register
// throughput one byte per cycle while the result side drains; input register feeds one pass of frame logic
// into the result register, both stages advance whenever the result side drains
// reset (synchronous, active low) clears both valid flags, byte count, type and sum
// depends on scd_pkg, scd_in_if, scd_out_if
module serial_can_frame_deframer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    scd_in_if.sink           i_rx,
    scd_out_if.source        o_res
);

    // input stage
    logic                          r_in_valid;
    logic [scd_pkg::BYTE_W-1:0]    r_in_byte;

    // frame state
    logic [scd_pkg::INDEX_W-1:0]   r_count, n_count;
    logic [scd_pkg::BYTE_W-1:0]    r_type, n_type;
    logic [scd_pkg::BYTE_W-1:0]    r_sum, n_sum;

    // result stage
    logic                          r_out_valid;
    logic [scd_pkg::BYTE_W-1:0]    r_out_byte;
    logic [scd_pkg::INDEX_W-1:0]   r_out_index;
    scd_pkg::t_kind                r_out_kind, n_kind;
    logic [scd_pkg::PLEN_W-1:0]    r_out_plen, n_plen;
    scd_pkg::t_status              r_out_status, n_status;
    logic                          r_out_end, n_end;

    logic                          w_out_load;
    logic                          w_in_take;
    logic [scd_pkg::BYTE_W-1:0]    w_type;
    logic [scd_pkg::INDEX_W:0]     w_next_pos;
    logic [scd_pkg::INDEX_W:0]     w_data_len;

    // handshake: result register frees when empty or taken
    assign w_out_load = !r_out_valid || o_res.ready;
    assign i_rx.ready = !r_in_valid || w_out_load;
    assign w_in_take  = i_rx.valid && i_rx.ready;

    // type in force: the byte itself at position one
    assign w_type     = (r_count == scd_pkg::INDEX_W'(1)) ? r_in_byte : r_type;
    assign w_next_pos = {1'b0, r_count} + (scd_pkg::INDEX_W+1)'(1);
    assign w_data_len = (scd_pkg::INDEX_W+1)'(w_type[scd_pkg::PLEN_W-1:0])
                        + (scd_pkg::INDEX_W+1)'(scd_pkg::DATA_EXTRA);

    // frame logic for the byte in the input register
    always_comb begin
        n_kind   = scd_pkg::KIND_UNKNOWN;
        n_plen   = '0;
        n_status = scd_pkg::ST_RECV;
        n_end    = 1'b0;
        n_count  = r_count;
        n_type   = r_type;
        n_sum    = r_sum;
        if (r_count == '0) begin
            if (r_in_byte != scd_pkg::START_BYTE) begin
                n_status = scd_pkg::ST_DISCARD;
            end else begin
                n_sum   = '0;
                n_count = scd_pkg::INDEX_W'(1);
            end
        end else begin
            n_type = w_type;
            if (w_type == scd_pkg::CMD_TYPE) begin
                n_kind = scd_pkg::KIND_CMD;
                if (r_count >= scd_pkg::INDEX_W'(scd_pkg::CMD_LEN - 1)) begin
                    n_status = (r_sum == r_in_byte) ? scd_pkg::ST_OK : scd_pkg::ST_CSUM_ERR;
                    n_end    = 1'b1;
                end else if (r_count >= scd_pkg::INDEX_W'(2)) begin
                    n_sum = r_sum + r_in_byte;
                end
            end else if (w_type[scd_pkg::BYTE_W-1:scd_pkg::PLEN_W] == scd_pkg::DATA_NIBBLE) begin
                n_kind = scd_pkg::KIND_DATA;
                n_plen = w_type[scd_pkg::PLEN_W-1:0];
                if (w_next_pos >= w_data_len) begin
                    n_status = scd_pkg::ST_OK;
                    n_end    = 1'b1;
                end
            end else begin
                n_kind   = scd_pkg::KIND_OTHER;
                n_status = scd_pkg::ST_OK;
                n_end    = 1'b1;
            end
            n_count = n_end ? '0 : w_next_pos[scd_pkg::INDEX_W-1:0];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (w_in_take) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // frame state and result register advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_type      <= '0;
            r_sum       <= '0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_count <= n_count;
                r_type  <= n_type;
                r_sum   <= n_sum;
            end
        end
        if (w_out_load && r_in_valid) begin
            r_out_byte   <= r_in_byte;
            r_out_index  <= r_count;
            r_out_kind   <= n_kind;
            r_out_plen   <= n_plen;
            r_out_status <= n_status;
            r_out_end    <= n_end;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.out_byte       = r_out_byte;
    assign o_res.byte_index     = r_out_index;
    assign o_res.frame_kind     = r_out_kind;
    assign o_res.payload_length = r_out_plen;
    assign o_res.frame_status   = r_out_status;
    assign o_res.frame_end      = r_out_end;

endmodule

// ----- rtl/core/scd_checker.sv -----
// port-level checks for the serial can frame deframer, bound to the top level
// depends on scd_pkg and serial_can_frame_deframer
module scd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_ready,
    input  logic [scd_pkg::BYTE_W-1:0]    i_out_byte,
    input  logic [scd_pkg::INDEX_W-1:0]   i_byte_index,
    input  scd_pkg::t_kind                i_frame_kind,
    input  logic [scd_pkg::PLEN_W-1:0]    i_payload_length,
    input  scd_pkg::t_status              i_frame_status,
    input  logic                          i_frame_end
);

    // a stalled result word holds its byte
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_byte) && $stable(i_byte_index))
        else $error("result word changed while stalled");

    // a frame only ends with a final status
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_end |->
            i_frame_status == scd_pkg::ST_OK || i_frame_status == scd_pkg::ST_CSUM_ERR)
        else $error("frame end without final status");

    // discarded bytes sit at position zero with no kind
    a_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_status == scd_pkg::ST_DISCARD |->
            i_byte_index == '0 && i_frame_kind == scd_pkg::KIND_UNKNOWN && !i_frame_end)
        else $error("discard away from frame start");

    // checksum errors only on the last byte of a command frame
    a_csum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_status == scd_pkg::ST_CSUM_ERR |->
            i_frame_kind == scd_pkg::KIND_CMD &&
            i_byte_index == scd_pkg::INDEX_W'(scd_pkg::CMD_LEN - 1))
        else $error("checksum error off the command frame end");

    // a payload length is reported for data frames only
    a_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_payload_length != '0 |-> i_frame_kind == scd_pkg::KIND_DATA)
        else $error("payload length on a non-data word");

endmodule

bind serial_can_frame_deframer scd_checker u_scd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_res.valid),
    .i_ready          (o_res.ready),
    .i_out_byte       (o_res.out_byte),
    .i_byte_index     (o_res.byte_index),
    .i_frame_kind     (o_res.frame_kind),
    .i_payload_length (o_res.payload_length),
    .i_frame_status   (o_res.frame_status),
    .i_frame_end      (o_res.frame_end)
);
